FILE: hw/rtl/fpa_pkg.sv
// Shared opcodes, widths and pipeline metadata for the fixed-point ALU.
`default_nettype none
package fpa_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 4;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_EQ   = 4'd4,
    OP_NE   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_GT   = 4'd8,
    OP_LT   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_FINT = 4'd14,
    OP_TINT = 4'd15
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_WRAP = 2'd2
  } status_t;

  // Travels alongside the divider stages.
  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              cmp;
    logic              wrap;
  } meta_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fpa_front.sv
// Front end: operand decode, simple ops, multiply and divider setup.
`default_nettype none
module fpa_front #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_vld,
  input  wire [fpa_pkg::OP_W-1:0]               in_opcode,
  input  wire [fpa_pkg::DATA_W-1:0]             in_a,
  input  wire [fpa_pkg::DATA_W-1:0]             in_b,
  output logic                                  out_vld,
  output fpa_pkg::meta_t                        out_meta,
  output logic [WORD_BITS+FRAC_BITS-1:0]        out_num,
  output logic [WORD_BITS-1:0]                  out_den
);
  import fpa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + F;

  // stage 1: decode and simple ops
  logic                v1_r;
  op_t                 op1_r;
  logic signed [W-1:0] a1_r, b1_r;
  logic [W-1:0]        res1_r;
  logic                cmp1_r, wrap1_r;

  logic signed [W-1:0] a0, b0;
  logic signed [W:0]   sum0;
  logic signed [NW-1:0] fint0;
  logic [W-1:0]        res0;
  logic                cmp0, wrap0;
  op_t                 op0;

  always_comb begin
    op0   = op_t'(in_opcode);
    a0    = $signed(in_a[W-1:0]);
    b0    = $signed(in_b[W-1:0]);
    sum0  = '0;
    fint0 = NW'(a0) <<< F;
    res0  = '0;
    cmp0  = 1'b0;
    wrap0 = 1'b0;
    case (op0)
      OP_ADD: sum0 = (W+1)'(a0) + (W+1)'(b0);
      OP_SUB: sum0 = (W+1)'(a0) - (W+1)'(b0);
      OP_INC: sum0 = (W+1)'(a0) + (W+1)'(1);
      OP_DEC: sum0 = (W+1)'(a0) - (W+1)'(1);
      default: sum0 = '0;
    endcase
    case (op0)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        res0  = sum0[W-1:0];
        wrap0 = sum0[W] ^ sum0[W-1];
      end
      OP_EQ:  cmp0 = (a0 == b0);
      OP_NE:  cmp0 = (a0 != b0);
      OP_GE:  cmp0 = (a0 >= b0);
      OP_LE:  cmp0 = (a0 <= b0);
      OP_GT:  cmp0 = (a0 > b0);
      OP_LT:  cmp0 = (a0 < b0);
      OP_MIN: res0 = (a0 <= b0) ? a0 : b0;
      OP_MAX: res0 = (a0 >= b0) ? a0 : b0;
      OP_FINT: begin
        res0  = fint0[W-1:0];
        wrap0 = (fint0 != NW'($signed(fint0[W-1:0])));
      end
      OP_TINT: res0 = W'(a0 >>> F);
      default: res0 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    op1_r   <= op0;
    a1_r    <= a0;
    b1_r    <= b0;
    res1_r  <= res0;
    cmp1_r  <= cmp0;
    wrap1_r <= wrap0;
  end

  // stage 2: product and magnitudes
  logic                  v2_r;
  op_t                   op2_r;
  logic signed [2*W-1:0] prod2_r;
  logic [W-1:0]          res2_r, maga2_r, magb2_r;
  logic                  cmp2_r, wrap2_r, neg2_r, dz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    op2_r   <= op1_r;
    prod2_r <= (2*W)'(a1_r) * (2*W)'(b1_r);
    res2_r  <= res1_r;
    cmp2_r  <= cmp1_r;
    wrap2_r <= wrap1_r;
    maga2_r <= a1_r[W-1] ? W'(-a1_r) : W'(a1_r);
    magb2_r <= b1_r[W-1] ? W'(-b1_r) : W'(b1_r);
    neg2_r  <= a1_r[W-1] ^ b1_r[W-1];
    dz2_r   <= (b1_r == '0);
  end

  // stage 3: product scaling, divider operands
  logic signed [2*W-1:0] psh;
  logic [W-1:0]          res3;
  logic                  wrap3;
  meta_t                 meta3;

  always_comb begin
    psh   = prod2_r >>> F;
    res3  = res2_r;
    wrap3 = wrap2_r;
    if (op2_r == OP_MUL) begin
      res3  = psh[W-1:0];
      wrap3 = (psh != (2*W)'($signed(psh[W-1:0])));
    end
    meta3.is_div = (op2_r == OP_DIV);
    meta3.dz     = dz2_r;
    meta3.neg    = neg2_r;
    meta3.res    = DATA_W'($signed(res3));
    meta3.cmp    = cmp2_r;
    meta3.wrap   = wrap3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_meta <= meta3;
    out_num  <= {maga2_r, {F{1'b0}}};
    out_den  <= magb2_r;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module fpa_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_vld,
  input  wire fpa_pkg::meta_t                 in_meta,
  input  wire [WORD_BITS+FRAC_BITS-1:0]       in_num,
  input  wire [WORD_BITS-1:0]                 in_den,
  output logic                                out_vld,
  output fpa_pkg::meta_t                      out_meta,
  output logic [WORD_BITS+FRAC_BITS-1:0]      out_quot
);
  import fpa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NW = WORD_BITS + FRAC_BITS;

  logic          vld_r  [1:NW];
  meta_t         meta_r [1:NW];
  logic [W-1:0]  rem_r  [1:NW];
  logic [W-1:0]  den_r  [1:NW];
  logic [NW-1:0] num_r  [1:NW];
  logic [NW-1:0] q_r    [1:NW];

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic          pv;
    meta_t         pm;
    logic [W-1:0]  prem, pden;
    logic [NW-1:0] pnum, pq;
    logic [W:0]    trial;
    logic          ge;

    if (k == 1) begin : g_first
      assign pv   = in_vld;
      assign pm   = in_meta;
      assign prem = '0;
      assign pden = in_den;
      assign pnum = in_num;
      assign pq   = '0;
    end else begin : g_next
      assign pv   = vld_r[k-1];
      assign pm   = meta_r[k-1];
      assign prem = rem_r[k-1];
      assign pden = den_r[k-1];
      assign pnum = num_r[k-1];
      assign pq   = q_r[k-1];
    end

    assign trial = {prem, pnum[NW-1]};
    assign ge    = (trial >= {1'b0, pden});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      meta_r[k] <= pm;
      den_r[k]  <= pden;
      num_r[k]  <= {pnum[NW-2:0], 1'b0};
      q_r[k]    <= {pq[NW-2:0], ge};
      rem_r[k]  <= ge ? W'(trial - {1'b0, pden}) : trial[W-1:0];
    end
  end

  assign out_vld  = vld_r[NW];
  assign out_meta = meta_r[NW];
  assign out_quot = q_r[NW];

endmodule
`default_nettype wire

FILE: hw/rtl/fpa_back.sv
// Result select, quotient sign and wrap check, output register.
`default_nettype none
module fpa_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_vld,
  input  wire fpa_pkg::meta_t             in_meta,
  input  wire [WORD_BITS+FRAC_BITS-1:0]   in_quot,
  output logic                            out_vld,
  output logic [fpa_pkg::DATA_W-1:0]      out_res,
  output logic                            out_cmp,
  output logic [fpa_pkg::STAT_W-1:0]      out_stat
);
  import fpa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int NW = WORD_BITS + FRAC_BITS;
  localparam logic [NW-1:0] LIM = NW'(1) << (W - 1);

  logic [W-1:0]      qv;
  logic [DATA_W-1:0] res;
  logic              wrap;
  status_t           st;

  always_comb begin
    qv   = in_meta.neg ? W'(-in_quot[W-1:0]) : in_quot[W-1:0];
    res  = in_meta.res;
    wrap = in_meta.wrap;
    if (in_meta.is_div) begin
      if (in_meta.dz) begin
        res  = '0;
        wrap = 1'b0;
      end else begin
        res  = DATA_W'($signed(qv));
        wrap = in_meta.neg ? (in_quot > LIM) : (in_quot >= LIM);
      end
    end
    if (in_meta.is_div && in_meta.dz) begin
      st = ST_DIV0;
    end else if (wrap) begin
      st = ST_WRAP;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_res  <= res;
    out_cmp  <= in_meta.cmp;
    out_stat <= st;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fixed_point_q24_8_alu.sv
// Top level of the pipelined signed fixed-point ALU.
// A request passes from start to out_valid through the front end, the divider stages and
//   the back end, the same for every opcode (Q24.8 by default); one quotient bit per stage.
// Throughput: one request per cycle; busy is always low.
// Reset (rst_n, synchronous, active low) clears the valid bits of every stage;
//   requests in flight are dropped. Results are strobed for one cycle, no stall.
`default_nettype none
module fixed_point_q24_8_alu #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire [fpa_pkg::OP_W-1:0]       in_opcode,
  input  wire [fpa_pkg::DATA_W-1:0]     in_operand_a,
  input  wire [fpa_pkg::DATA_W-1:0]     in_operand_b,
  output logic                          out_valid,
  output logic [fpa_pkg::DATA_W-1:0]    out_result_value,
  output logic                          out_compare_true,
  output logic [fpa_pkg::STAT_W-1:0]    out_status
);
  import fpa_pkg::*;

  localparam int NW  = WORD_BITS + FRAC_BITS;
  localparam int LAT = NW + 4;

  // Every stage advances each cycle, so a request is never refused.
  assign busy = 1'b0;

  logic                 fr_vld;
  meta_t                fr_meta;
  logic [NW-1:0]        fr_num;
  logic [WORD_BITS-1:0] fr_den;

  logic                 dv_vld;
  meta_t                dv_meta;
  logic [NW-1:0]        dv_quot;

  // Three stages: decode/simple ops, product, scaling plus divider setup.
  fpa_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_opcode(in_opcode),
    .in_a     (in_operand_a),
    .in_b     (in_operand_b),
    .out_vld  (fr_vld),
    .out_meta (fr_meta),
    .out_num  (fr_num),
    .out_den  (fr_den)
  );

  // Every request flows through the divider stages to keep latency uniform;
  // non-divide results ride along in the metadata.
  fpa_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (fr_vld),
    .in_meta (fr_meta),
    .in_num  (fr_num),
    .in_den  (fr_den),
    .out_vld (dv_vld),
    .out_meta(dv_meta),
    .out_quot(dv_quot)
  );

  // Final select and output register.
  fpa_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (dv_vld),
    .in_meta (dv_meta),
    .in_quot (dv_quot),
    .out_vld (out_valid),
    .out_res (out_result_value),
    .out_cmp (out_compare_true),
    .out_stat(out_status)
  );

  // A result only appears a fixed latency after a request.
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching request");

  // Status code 3 is never produced.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("illegal status code");

  // A true comparison carries a zero value and ok status.
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_true) |-> (out_result_value == '0 && out_status == ST_OK))
    else $error("comparison result not clean");

  // Divide-by-zero always reports a zero value.
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIV0) |-> (out_result_value == '0))
    else $error("divide by zero with nonzero value");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the Q24.8 fixed-point ALU: random and directed requests vs. a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int FRAC     = 8;
  localparam int LATENCY  = 44;
  localparam int WDOG_MAX = 2000;

  // One predicted ALU answer.
  typedef struct {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  stat;
  } alu_answer_t;

  int n_errors = 0;

  // Prints one line per mismatch and counts it.
  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Predicts results for accepted requests and checks the block's answers in order.
  class alu_scoreboard;
    alu_answer_t pending[$];

    // Floor shift right by FRAC of a wide signed value.
    function automatic longint floor_shr(input longint v);
      return v >>> FRAC;
    endfunction

    function automatic alu_answer_t compute(input op_t op, input logic [31:0] ra,
                                            input logic [31:0] rb);
      longint a, b, r, w;
      logic   wrapped;
      alu_answer_t ans;
      a = longint'($signed(ra));
      b = longint'($signed(rb));
      r = 0;
      wrapped = 1'b0;
      ans.cmp = 1'b0;
      ans.stat = ST_OK;
      case (op)
        OP_ADD:  r = a + b;
        OP_SUB:  r = a - b;
        OP_MUL:  r = floor_shr(a * b);
        OP_DIV: begin
          // Division by zero gives zero with its own status; quotient truncates toward zero.
          if (b == 0) ans.stat = ST_DIV0;
          else r = (a * 256) / b;
        end
        OP_EQ:   ans.cmp = (a == b);
        OP_NE:   ans.cmp = (a != b);
        OP_GE:   ans.cmp = (a >= b);
        OP_LE:   ans.cmp = (a <= b);
        OP_GT:   ans.cmp = (a > b);
        OP_LT:   ans.cmp = (a < b);
        OP_MIN:  r = (a <= b) ? a : b;
        OP_MAX:  r = (a >= b) ? a : b;
        OP_INC:  r = a + 1;
        OP_DEC:  r = a - 1;
        OP_FINT: r = a * 256;
        default: r = floor_shr(a);
      endcase
      w = longint'($signed(r[31:0]));
      if (w != r) wrapped = 1'b1;
      if (ans.stat == ST_OK && wrapped) ans.stat = ST_WRAP;
      ans.value = r[31:0];
      return ans;
    endfunction

    function void note_request(input op_t op, input logic [31:0] a, input logic [31:0] b);
      pending.push_back(compute(op, a, b));
    endfunction

    task check_result(input logic [31:0] v, input logic c, input logic [1:0] s);
      alu_answer_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%h", v));
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) report($sformatf("value %h, want %h", v, e.value));
      if (c !== e.cmp) report($sformatf("compare_true %b, want %b", c, e.cmp));
      if (s !== e.stat) report($sformatf("status %0d, want %0d", s, e.stat));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_opcode = '0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic [31:0] out_result_value;
  logic        out_compare_true;
  logic [1:0]  out_status;

  alu_scoreboard sb = new();
  int idle_pct = 0;   // chance in percent that the sender skips a cycle
  int wdog = 0;

  always #4 clk = ~clk;

  fixed_point_q24_8_alu dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result_value(out_result_value),
    .out_compare_true(out_compare_true), .out_status(out_status)
  );

  // Sample at the rising edge: accepted requests go to the predictor, strobed results to the check.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_request(op_t'(in_opcode), in_operand_a, in_operand_b);
      if (out_valid) sb.check_result(out_result_value, out_compare_true, out_status);
      // Watchdog: cycles with nothing accepted on either side.
      if ((start && !busy) || out_valid) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Drives one request: random idle gaps first, then hold start until accepted.
  task automatic send(input op_t op, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Operand mix: corner values, small random values, or fully random bits.
  function automatic logic [31:0] pick_operand();
    logic [31:0] corners[8] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h100, 32'hFFFF_FF00, 32'h0080_0000};
    case ($urandom_range(3, 0))
      0: return corners[$urandom_range(7, 0)];
      1: return $signed($urandom_range(4096, 0)) - 2048;
      default: return $urandom;
    endcase
  endfunction

  // Lets the pipe drain: start low until no expectation remains.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [31:0] a, b;
    logic [31:0] edges[5] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h100};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every opcode on extremes, plus divide by zero and wrapping cases.
    for (int op = 0; op < 16; op++)
      send(op_t'(op), edges[op % 5], edges[(op + 2) % 5]);
    send(OP_DIV, 32'h0000_0500, 32'h0);
    send(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    send(OP_INC, 32'h7FFF_FFFF, 32'h0);
    send(OP_DEC, 32'h8000_0000, 32'h0);
    send(OP_FINT, 32'h0080_0000, 32'h0);
    send(OP_MIN, 32'h1234, 32'h1234);
    send(OP_TINT, 32'hFFFF_FFFF, 32'h0);

    // Sender pauses until everything has come back.
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 31 : (phase == 1) ? 65 : 0;
      for (int i = 0; i < 610; i++) begin
        a = pick_operand();
        b = ($urandom_range(15, 0) == 0) ? 32'h0 : pick_operand();
        send(op_t'($urandom_range(15, 0)), a, b);
      end
    end
    drain();
    repeat (LATENCY + 10) @(negedge clk);

    if (n_errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
